>>> hdl/rvc_quadrant1_expander_top_macros.svh
`ifndef RVC_QUADRANT1_EXPANDER_TOP_MACROS_SVH
`define RVC_QUADRANT1_EXPANDER_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define RVCQ1_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rvcq1 check failed");

// Next-cycle implication, checked while out of reset.
`define RVCQ1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rvcq1 check failed");

`endif

>>> hdl/rvcq1_pkg.sv
package rvcq1_pkg;

  localparam int unsigned CinstW = 16;
  localparam int unsigned InstW  = 32;

  localparam logic [1:0] QUAD1 = 2'b01;

  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_JAL   = 3'd1;
  localparam logic [2:0] F3_LI    = 3'd2;
  localparam logic [2:0] F3_LUI   = 3'd3;
  localparam logic [2:0] F3_MISC  = 3'd4;

  localparam logic [1:0] MISC_SRLI = 2'd0;
  localparam logic [1:0] MISC_SRAI = 2'd1;
  localparam logic [1:0] MISC_ANDI = 2'd2;
  localparam logic [1:0] MISC_ARITH = 2'd3;

  localparam logic [1:0] ARITH_SUB = 2'd0;
  localparam logic [1:0] ARITH_XOR = 2'd1;
  localparam logic [1:0] ARITH_OR  = 2'd2;
  localparam logic [1:0] ARITH_AND = 2'd3;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  localparam logic [2:0] FN3_ADD  = 3'd0;
  localparam logic [2:0] FN3_XOR  = 3'd4;
  localparam logic [2:0] FN3_SR   = 3'd5;
  localparam logic [2:0] FN3_OR   = 3'd6;
  localparam logic [2:0] FN3_AND  = 3'd7;

  localparam logic [6:0] FN7_BASE = 7'h00;
  localparam logic [6:0] FN7_SUB  = 7'h20;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_SP   = 5'd2;

  typedef struct packed {
    logic [InstW-1:0] expanded_instruction;
    logic             illegal;
  } res_t;

endpackage

>>> hdl/rvcq1_in_if.sv
interface rvcq1_in_if import rvcq1_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CinstW-1:0] short_instruction;

  modport source (output valid, output short_instruction, input ready);
  modport sink (input valid, input short_instruction, output ready);
endinterface

>>> hdl/rvcq1_out_if.sv
interface rvcq1_out_if import rvcq1_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [InstW-1:0] expanded_instruction;
  logic             illegal;

  modport source (output valid, output expanded_instruction, output illegal, input ready);
  modport sink (input valid, input expanded_instruction, input illegal, output ready);
endinterface

>>> hdl/rvc_quadrant1_expander_top.sv
// Channel | Dir | Carries
// in_i    | in  | short_instruction (16 b compressed quadrant-1 word)
// out_o   | out | expanded_instruction (32 b RV32I word), illegal
//
// One item per cycle sustained while out_o.ready is high.
// The input register and the result register each set one stage; decode sits between.
// Reset clears both stage valid flags; payload registers are not reset.
// A stalled result holds in the result register while one more item waits
// in the input register; in_i.ready drops only when both are full.
`include "rvc_quadrant1_expander_top_macros.svh"

module rvc_quadrant1_expander_top import rvcq1_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  rvcq1_in_if.sink     in_i,
  rvcq1_out_if.source  out_o
);

  logic              s1_valid;
  logic              s1_ready;
  logic [CinstW-1:0] s1_instr;
  res_t              dec_res;
  res_t              out_res;

  rvcq1_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .instr_i (in_i.short_instruction),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .instr_o (s1_instr)
  );

  rvcq1_decode u_decode (
    .instr_i (s1_instr),
    .res_o   (dec_res)
  );

  rvcq1_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .res_i   (dec_res),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.expanded_instruction = out_res.expanded_instruction;
  assign out_o.illegal              = out_res.illegal;

  `RVCQ1_ASSERT_NOW(a_illegal_zero, out_o.valid && out_o.illegal, out_o.expanded_instruction == '0)
  `RVCQ1_ASSERT_NOW(a_legal_opcode, out_o.valid && !out_o.illegal, out_o.expanded_instruction[1:0] == 2'b11)
  `RVCQ1_ASSERT_NEXT(a_accept_fills_s1, in_i.valid && in_i.ready, s1_valid)
  `RVCQ1_ASSERT_NEXT(a_s1_moves_out, s1_valid && s1_ready, out_o.valid)

endmodule

>>> hdl/rvcq1_in_reg.sv
module rvcq1_in_reg import rvcq1_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [CinstW-1:0] instr_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CinstW-1:0] instr_o
);

  logic              valid_q, valid_d;
  logic [CinstW-1:0] instr_q;
  logic              load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      instr_q <= instr_i;
    end
  end

  assign valid_o = valid_q;
  assign instr_o = instr_q;

endmodule

>>> hdl/rvcq1_decode.sv
module rvcq1_decode import rvcq1_pkg::*; (
  input  logic [CinstW-1:0] instr_i,
  output res_t              res_o
);

  logic [2:0]  f3;
  logic        b12;
  logic [4:0]  lo5;
  logic [4:0]  rd5;
  logic [4:0]  rdp;
  logic [4:0]  rs2p;
  logic [11:0] imm6;
  logic [11:0] imm16sp;
  logic [11:0] shimm;
  logic [19:0] upimm;
  logic [2:0]  afn3;
  logic [6:0]  afn7;
  logic [31:0] word;
  logic        bad;

  assign f3      = instr_i[15:13];
  assign b12     = instr_i[12];
  assign lo5     = instr_i[6:2];
  assign rd5     = instr_i[11:7];
  assign rdp     = {2'b01, instr_i[9:7]};
  assign rs2p    = {2'b01, instr_i[4:2]};
  assign imm6    = {{7{b12}}, lo5};
  assign imm16sp = {{3{b12}}, instr_i[4:3], instr_i[5], instr_i[2], instr_i[6], 4'b0000};
  assign shimm   = {1'b0, instr_i[10], 5'b00000, lo5};
  assign upimm   = {{15{b12}}, lo5};

  always_comb begin
    unique case (instr_i[6:5])
      ARITH_SUB: begin afn3 = FN3_ADD; afn7 = FN7_SUB;  end
      ARITH_XOR: begin afn3 = FN3_XOR; afn7 = FN7_BASE; end
      ARITH_OR:  begin afn3 = FN3_OR;  afn7 = FN7_BASE; end
      ARITH_AND: begin afn3 = FN3_AND; afn7 = FN7_BASE; end
      default:   begin afn3 = FN3_AND; afn7 = FN7_BASE; end
    endcase
  end

  always_comb begin
    word = '0;
    bad  = 1'b0;
    if (instr_i[1:0] != QUAD1) begin
      bad = 1'b1;
    end else begin
      unique case (f3)
        F3_ADDI: begin
          word = {imm6, rd5, FN3_ADD, rd5, OPC_OP_IMM};
        end
        F3_LI: begin
          word = {imm6, REG_ZERO, FN3_ADD, rd5, OPC_OP_IMM};
        end
        F3_LUI: begin
          if (lo5 == 5'd0 && !b12) begin
            bad = 1'b1;
          end else if (rd5 == REG_SP) begin
            word = {imm16sp, REG_SP, FN3_ADD, REG_SP, OPC_OP_IMM};
          end else begin
            word = {upimm, rd5, OPC_LUI};
          end
        end
        F3_MISC: begin
          unique case (instr_i[11:10])
            MISC_SRLI, MISC_SRAI: begin
              if (b12 || lo5 == 5'd0) begin
                bad = 1'b1;
              end else begin
                word = {shimm, rdp, FN3_SR, rdp, OPC_OP_IMM};
              end
            end
            MISC_ANDI: begin
              word = {imm6, rdp, FN3_AND, rdp, OPC_OP_IMM};
            end
            MISC_ARITH: begin
              if (b12) begin
                bad = 1'b1;
              end else begin
                word = {afn7, rs2p, rdp, afn3, rdp, OPC_OP};
              end
            end
            default: bad = 1'b1;
          endcase
        end
        default: bad = 1'b1;
      endcase
    end
  end

  assign res_o.expanded_instruction = bad ? '0 : word;
  assign res_o.illegal              = bad;

endmodule

>>> hdl/rvcq1_out_reg.sv
module rvcq1_out_reg import rvcq1_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  res_t res_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
